// ===== hw/rtl/egp_pkg.sv =====
package egp_pkg;

  localparam int MAX_ROWS = 256;
  localparam int ROW_W    = $clog2(MAX_ROWS);

  localparam int COL_W  = 10;
  localparam int GSZ_W  = 7;
  localparam int CHAR_W = 8;

  localparam int DSTX_W = 17;
  localparam int DSTY_W = 15;
  localparam int SRC_W  = 10;

  localparam int CFG_ADDR_W = 4;
  localparam logic [CFG_ADDR_W-1:0] ADDR_GLYPHS_PER_LINE = 4'h0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_GLYPH_WIDTH     = 4'h4;
  localparam logic [CFG_ADDR_W-1:0] ADDR_GLYPH_HEIGHT    = 4'h8;

  localparam logic [COL_W-1:0] GLYPHS_PER_LINE_RST = 10'd80;
  localparam logic [GSZ_W-1:0] GLYPH_WIDTH_RST     = 7'd8;
  localparam logic [GSZ_W-1:0] GLYPH_HEIGHT_RST    = 7'd8;

  localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_B      = 8'h62;
  localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;

  localparam logic [23:0] NAME_FCB = 24'h464342;
  localparam logic [23:0] NAME_FCO = 24'h46434F;
  localparam logic [23:0] NAME_FCD = 24'h464344;
  localparam logic [23:0] NAME_FCH = 24'h464348;

  localparam logic [4:0] BASE_BIN = 5'd2;
  localparam logic [4:0] BASE_OCT = 5'd8;
  localparam logic [4:0] BASE_DEC = 5'd10;
  localparam logic [4:0] BASE_HEX = 5'd16;

  localparam logic [2:0] NUM_COMPONENTS = 3'd4;
  localparam logic [5:0] NO_DIGIT       = 6'd63;

  typedef enum logic [1:0] {
    KIND_GLYPH = 2'd0,
    KIND_COLOR = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [CHAR_W-1:0]  glyph_code;
    logic [SRC_W-1:0]   src_x;
    logic [SRC_W-1:0]   src_y;
    logic [DSTX_W-1:0]  dst_x;
    logic [DSTY_W-1:0]  dst_y;
    logic [7:0]         color_red;
    logic [7:0]         color_green;
    logic [7:0]         color_blue;
    logic [7:0]         color_alpha;
  } result_t;

endpackage

// ===== hw/rtl/egp_ram.sv =====
module egp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/escaped_text_glyph_placer.sv =====
// Places glyphs for a byte stream of text with backslash escapes and color codes. One byte
// is taken per clock cycle while the skid stage is empty. Its result (glyph placement, color
// change or number error; many bytes give none) is registered into an output register, or into
// a one-entry skid stage while the output is held; the two decouple the sides, so the slave
// side stalls only when both hold undelivered results. The per-row end columns live in a
// 256 x 10 RAM with a registered read; the entry of the row above the cursor's previous row
// is fetched every cycle ahead of need, so a backspace across a row boundary does not stall.
// Registers (APB): 0x0 glyphs_per_line, 0x4 glyph_width, 0x8 glyph_height; write them only
// while the block is idle.
module escaped_text_glyph_placer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // char_code
  input  logic [0:0]                         s_axis_tuser,  // first_of_string
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // glyph_code, src_x, src_y, dst_x, dst_y, color_red, color_green, color_blue, color_alpha
  output logic [95:0]                        m_axis_tdata,
  output logic [1:0]                         m_axis_tuser,  // result_kind
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [egp_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int ROW_W  = egp_pkg::ROW_W;
  localparam int COL_W  = egp_pkg::COL_W;
  localparam int DYP_W  = (ROW_W + 8 > egp_pkg::DSTY_W) ? ROW_W + 8 : egp_pkg::DSTY_W;

  // configuration
  logic [COL_W-1:0]          glyphs_per_line;
  logic [egp_pkg::GSZ_W-1:0] glyph_width;
  logic [egp_pkg::GSZ_W-1:0] glyph_height;
  logic                      cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyphs_per_line <= egp_pkg::GLYPHS_PER_LINE_RST;
      glyph_width     <= egp_pkg::GLYPH_WIDTH_RST;
      glyph_height    <= egp_pkg::GLYPH_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (paddr)
        egp_pkg::ADDR_GLYPHS_PER_LINE: glyphs_per_line <= pwdata[COL_W-1:0];
        egp_pkg::ADDR_GLYPH_WIDTH:     glyph_width     <= pwdata[egp_pkg::GSZ_W-1:0];
        egp_pkg::ADDR_GLYPH_HEIGHT:    glyph_height    <= pwdata[egp_pkg::GSZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      egp_pkg::ADDR_GLYPHS_PER_LINE: prdata = {22'd0, glyphs_per_line};
      egp_pkg::ADDR_GLYPH_WIDTH:     prdata = {25'd0, glyph_width};
      egp_pkg::ADDR_GLYPH_HEIGHT:    prdata = {25'd0, glyph_height};
      default:                       prdata = 32'd0;
    endcase
  end

  // cursor and parser state
  logic [COL_W-1:0] cursor_column, cursor_column_next;
  logic [ROW_W-1:0] cursor_row, cursor_row_next;
  logic             escape_pending, escape_pending_next;
  logic             code_open, code_open_next;
  logic [23:0]      code_name, code_name_next;
  logic [2:0]       code_name_length, code_name_length_next;
  logic [4:0]       number_base, number_base_next;
  logic [7:0]       digit_value, digit_value_next;
  logic             digit_seen, digit_seen_next;
  logic             digit_stopped, digit_stopped_next;
  logic [2:0]       component_index, component_index_next;
  logic [31:0]      pending_color, pending_color_next;
  logic [COL_W-1:0] prev_end, prev_end_next;
  logic             use_rdata, use_rdata_next;

  // row end store
  logic             ram_we;
  logic [ROW_W-1:0] ram_waddr;
  logic [COL_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_raddr;
  logic [COL_W-1:0] ram_rdata;

  assign ram_raddr = cursor_row - ROW_W'(2);

  egp_ram #(
    .WIDTH (COL_W),
    .DEPTH (egp_pkg::MAX_ROWS)
  ) u_row_end (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register and skid stage
  egp_pkg::result_t out_q, skid_q, push_data;
  logic             out_valid, skid_valid, push, has_result;
  logic             accept;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push          = accept && has_result;

  // effective state after an optional string start
  logic             fos;
  logic [7:0]       c;
  logic [COL_W-1:0] col_e;
  logic [ROW_W-1:0] row_e;
  logic [COL_W-1:0] prev_e;
  logic             esc_e;

  assign fos    = s_axis_tuser[0];
  assign c      = s_axis_tdata;
  assign col_e  = fos ? '0 : cursor_column;
  assign row_e  = fos ? '0 : cursor_row;
  assign esc_e  = fos ? 1'b0 : escape_pending;
  assign prev_e = use_rdata ? ram_rdata : prev_end;

  // placement arithmetic
  logic [10:0]              src_x_full, src_y_full;
  logic [COL_W+7:0]         dst_x_full;
  logic [DYP_W-1:0]         dst_y_full;
  logic [7:0]               pad_w, pad_h;
  logic                     wrap;

  assign pad_w      = {1'b0, glyph_width} + 8'd2;
  assign pad_h      = {1'b0, glyph_height} + 8'd2;
  assign src_x_full = 11'(c[3:0]) * 11'(glyph_width);
  assign src_y_full = 11'(c[7:4]) * 11'(glyph_height);
  assign dst_x_full = (COL_W+8)'(col_e) * (COL_W+8)'(pad_w);
  assign dst_y_full = DYP_W'(row_e) * DYP_W'(pad_h);
  assign wrap       = ({1'b0, col_e} + 11'd1) >= {1'b0, glyphs_per_line};

  // digit decode
  logic [5:0] digit;
  logic       is_space;

  always_comb begin
    if (c >= 8'h30 && c <= 8'h39) begin
      digit = 6'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      digit = 6'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      digit = 6'(c - 8'h37);
    end else begin
      digit = egp_pkg::NO_DIGIT;
    end
  end

  assign is_space = (c == egp_pkg::CH_SPACE) || (c >= egp_pkg::CH_TAB && c <= egp_pkg::CH_CR);

  logic [12:0] digit_prod;
  assign digit_prod = 13'(fos ? 8'd0 : digit_value) *
                      13'(fos ? egp_pkg::BASE_DEC : number_base) + 13'(digit);

  always_comb begin
    logic do_place, do_end, do_back, do_collect, do_finish, ok;
    egp_pkg::kind_t kind;

    cursor_column_next    = col_e;
    cursor_row_next       = row_e;
    escape_pending_next   = 1'b0;
    code_open_next        = fos ? 1'b0 : code_open;
    code_name_next        = fos ? 24'd0 : code_name;
    code_name_length_next = fos ? 3'd0 : code_name_length;
    number_base_next      = fos ? egp_pkg::BASE_DEC : number_base;
    digit_value_next      = fos ? 8'd0 : digit_value;
    digit_seen_next       = fos ? 1'b0 : digit_seen;
    digit_stopped_next    = fos ? 1'b0 : digit_stopped;
    component_index_next  = fos ? 3'd0 : component_index;
    pending_color_next    = fos ? 32'hFFFF_FFFF : pending_color;
    prev_end_next         = prev_e;
    use_rdata_next        = 1'b0;
    ram_we                = 1'b0;
    ram_waddr             = row_e;
    ram_wdata             = col_e;
    has_result            = 1'b0;
    kind                  = egp_pkg::KIND_GLYPH;
    do_place              = 1'b0;
    do_end                = 1'b0;
    do_back               = 1'b0;
    do_collect            = 1'b0;
    do_finish             = 1'b0;
    ok                    = 1'b1;

    case (c) inside
      egp_pkg::CH_BSLASH: begin
        do_place            = esc_e;
        escape_pending_next = !esc_e;
      end
      egp_pkg::CH_COLON: begin
        if (code_open_next) begin
          if (code_name_length_next == 3'd3) begin
            case (code_name_next)
              egp_pkg::NAME_FCB: number_base_next = egp_pkg::BASE_BIN;
              egp_pkg::NAME_FCO: number_base_next = egp_pkg::BASE_OCT;
              egp_pkg::NAME_FCD: number_base_next = egp_pkg::BASE_DEC;
              egp_pkg::NAME_FCH: number_base_next = egp_pkg::BASE_HEX;
              default: ;
            endcase
          end
          code_name_next        = 24'd0;
          code_name_length_next = 3'd0;
          digit_value_next      = 8'd0;
          digit_seen_next       = 1'b0;
          digit_stopped_next    = 1'b0;
        end else begin
          do_place = 1'b1;
        end
      end
      egp_pkg::CH_COMMA, egp_pkg::CH_RBRACK: begin
        if (code_open_next) begin
          do_finish = 1'b1;
        end else begin
          do_place = 1'b1;
        end
      end
      egp_pkg::CH_LBRACK: begin
        if (esc_e) begin
          code_open_next = 1'b1;
        end else begin
          do_place = 1'b1;
        end
      end
      egp_pkg::CH_BS: begin
        do_back = 1'b1;
      end
      egp_pkg::CH_LF: begin
        do_end = 1'b1;
      end
      egp_pkg::CH_B, egp_pkg::CH_N: begin
        if (code_open_next) begin
          do_collect = 1'b1;
        end else if (esc_e) begin
          do_back = (c == egp_pkg::CH_B);
          do_end  = (c == egp_pkg::CH_N);
        end else begin
          do_place = 1'b1;
        end
      end
      default: begin
        if (code_open_next) begin
          do_collect = 1'b1;
        end else begin
          do_place = 1'b1;
        end
      end
    endcase

    if (do_collect) begin
      if (code_name_length_next < 3'd3) begin
        code_name_next        = {code_name_next[15:0], c};
        code_name_length_next = code_name_length_next + 3'd1;
      end else begin
        code_name_length_next = 3'd4;
      end
      if (!digit_stopped_next) begin
        if (digit < {1'b0, number_base_next}) begin
          digit_value_next = digit_prod[7:0];
          digit_seen_next  = 1'b1;
        end else if (!(!digit_seen_next && is_space)) begin
          digit_stopped_next = 1'b1;
        end
      end
    end

    if (do_finish) begin
      has_result = 1'b1;
      if (component_index_next < egp_pkg::NUM_COMPONENTS) begin
        if (digit_seen_next) begin
          case (component_index_next[1:0])
            2'd0:    pending_color_next[31:24] = digit_value_next;
            2'd1:    pending_color_next[23:16] = digit_value_next;
            2'd2:    pending_color_next[15:8]  = digit_value_next;
            default: pending_color_next[7:0]   = digit_value_next;
          endcase
        end else begin
          ok = 1'b0;
        end
      end
      code_name_next        = 24'd0;
      code_name_length_next = 3'd0;
      digit_value_next      = 8'd0;
      digit_seen_next       = 1'b0;
      digit_stopped_next    = 1'b0;
      if (c == egp_pkg::CH_COMMA) begin
        if (component_index_next < egp_pkg::NUM_COMPONENTS) begin
          component_index_next = component_index_next + 3'd1;
        end
        has_result = !ok;
        kind       = egp_pkg::KIND_ERROR;
      end else begin
        component_index_next = 3'd0;
        code_open_next       = 1'b0;
        kind                 = ok ? egp_pkg::KIND_COLOR : egp_pkg::KIND_ERROR;
      end
    end

    if (do_place) begin
      has_result = 1'b1;
      kind       = egp_pkg::KIND_GLYPH;
      if (wrap) begin
        do_end = 1'b1;
      end else begin
        cursor_column_next = col_e + COL_W'(1);
      end
    end

    if (do_end) begin
      ram_we             = 1'b1;
      cursor_column_next = '0;
      if (row_e != ROW_W'(egp_pkg::MAX_ROWS - 1)) begin
        cursor_row_next = row_e + ROW_W'(1);
        prev_end_next   = col_e;
      end
    end

    if (do_back) begin
      if (col_e != '0) begin
        cursor_column_next = col_e - COL_W'(1);
      end else if (row_e != '0) begin
        cursor_row_next    = row_e - ROW_W'(1);
        cursor_column_next = prev_e;
        use_rdata_next     = 1'b1;
      end
    end

    push_data             = '0;
    push_data.kind        = kind;
    if (kind == egp_pkg::KIND_GLYPH) begin
      push_data.glyph_code = c;
      push_data.src_x      = src_x_full[egp_pkg::SRC_W-1:0];
      push_data.src_y      = src_y_full[egp_pkg::SRC_W-1:0];
      push_data.dst_x      = dst_x_full[egp_pkg::DSTX_W-1:0];
      push_data.dst_y      = dst_y_full[egp_pkg::DSTY_W-1:0];
    end else if (kind == egp_pkg::KIND_COLOR) begin
      push_data.color_red   = pending_color_next[31:24];
      push_data.color_green = pending_color_next[23:16];
      push_data.color_blue  = pending_color_next[15:8];
      push_data.color_alpha = pending_color_next[7:0];
    end

    if (!accept) begin
      ram_we     = 1'b0;
      has_result = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column    <= '0;
      cursor_row       <= '0;
      escape_pending   <= 1'b0;
      code_open        <= 1'b0;
      code_name        <= 24'd0;
      code_name_length <= 3'd0;
      number_base      <= egp_pkg::BASE_DEC;
      digit_value      <= 8'd0;
      digit_seen       <= 1'b0;
      digit_stopped    <= 1'b0;
      component_index  <= 3'd0;
      pending_color    <= 32'hFFFF_FFFF;
      use_rdata        <= 1'b0;
    end else if (accept) begin
      cursor_column    <= cursor_column_next;
      cursor_row       <= cursor_row_next;
      escape_pending   <= escape_pending_next;
      code_open        <= code_open_next;
      code_name        <= code_name_next;
      code_name_length <= code_name_length_next;
      number_base      <= number_base_next;
      digit_value      <= digit_value_next;
      digit_seen       <= digit_seen_next;
      digit_stopped    <= digit_stopped_next;
      component_index  <= component_index_next;
      pending_color    <= pending_color_next;
      use_rdata        <= use_rdata_next;
    end else begin
      use_rdata        <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prev_end <= accept ? prev_end_next : prev_e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      out_q <= skid_valid ? skid_q : push_data;
    end else if (push) begin
      skid_q <= push_data;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {4'd0, out_q.color_alpha, out_q.color_blue, out_q.color_green,
                          out_q.color_red, out_q.dst_y, out_q.dst_x, out_q.src_y,
                          out_q.src_x, out_q.glyph_code};

  // a row-end value taken from the ram only right after stepping back one row
  a_rdata_after_step_back: assert property (@(posedge clk) disable iff (rst)
    use_rdata |-> cursor_row == $past(cursor_row) - 1'b1)
    else $error("row end fetch out of step with cursor row");

  // the skid stage only fills behind a held output
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid holds a result while output is empty");

  // color and error results come only from an open code
  a_code_results: assert property (@(posedge clk) disable iff (rst)
    push && push_data.kind != egp_pkg::KIND_GLYPH |-> code_open && !fos)
    else $error("color result outside a code");

endmodule
